>>> sv/bsf_pkg.sv
// shared types and constants for the sample framer
package bsf_pkg;

    localparam int FRAME_SAMPLES_DEF = 25;
    localparam int ADC_BITS_DEF      = 12;
    localparam int ADC_IN_W          = 12;
    localparam int HDR_BYTES         = 6;

    localparam logic [31:0] MS_PER_S    = 32'd1000;
    localparam logic [7:0]  STATUS_MARK = 8'hFF;

    localparam logic [7:0] OP_START = 8'h01;
    localparam logic [7:0] OP_STOP  = 8'h02;
    localparam logic [7:0] OP_TIMED = 8'h03;

    localparam int FLAG_PLUS_BIT   = 0;
    localparam int FLAG_MINUS_BIT  = 1;
    localparam int FLAG_STREAM_BIT = 3;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_CTRL   = 2'd1,
        FUNC_STATUS = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_FRAME,
        EMIT_STATUS
    } emit_state_t;

    typedef struct packed {
        logic frame;
        logic status;
    } pkt_req_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] frame_time;
        logic [7:0]  flags;
    } hdr_t;

endpackage

>>> sv/bsf_if.sv
// item and result channel interfaces

interface bsf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [11:0] adc_value;
    logic        lead_plus_off;
    logic        lead_minus_off;
    logic [7:0]  opcode;
    logic [7:0]  arg;

    modport source (
        output valid, func, now_ms, adc_value, lead_plus_off, lead_minus_off, opcode, arg,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, adc_value, lead_plus_off, lead_minus_off, opcode, arg,
        output ready
    );
endinterface

interface bsf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_kind;
    logic       last;

    modport source (
        output valid, out_byte, packet_kind, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, packet_kind, last,
        output ready
    );
endinterface

>>> sv/bsf_packer.sv
// sample store and packet byte emitter
module bsf_packer #(
    parameter int FRAME_SAMPLES = bsf_pkg::FRAME_SAMPLES_DEF,
    parameter int ADC_BITS      = bsf_pkg::ADC_BITS_DEF,
    localparam int SAMPLE_W     = (ADC_BITS < bsf_pkg::ADC_IN_W) ? ADC_BITS : bsf_pkg::ADC_IN_W,
    localparam int IDX_W        = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [SAMPLE_W-1:0]   wr_data,
    input  bsf_pkg::pkt_req_t     req,
    input  bsf_pkg::hdr_t         hdr,
    output logic                  busy,
    bsf_result_if.source          result
);

    localparam int TOTAL = bsf_pkg::HDR_BYTES + 2 * FRAME_SAMPLES;
    localparam int CNT_W = $clog2(TOTAL);
    localparam logic [15:0] OFFSET = 16'(1 << (ADC_BITS - 1));

    logic [SAMPLE_W-1:0] store_mem [FRAME_SAMPLES];
    logic [SAMPLE_W-1:0] rd_data_reg;

    bsf_pkg::emit_state_t state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [7:0]           hi_reg, hi_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_kind_reg, out_kind_next;
    logic                 out_last_reg, out_last_next;

    logic                 advance;
    logic [15:0]          sample_ofs;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    assign sample_ofs = {{(16 - SAMPLE_W){1'b0}}, rd_data_reg} - OFFSET;
    assign advance    = (state_reg != bsf_pkg::EMIT_IDLE) && (!out_valid_reg || result.ready);
    assign busy       = (state_reg != bsf_pkg::EMIT_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bsf_pkg::EMIT_IDLE:
            begin
                if (req.frame)
                begin
                    state_next  = bsf_pkg::EMIT_FRAME;
                    cnt_next    = '0;
                    rd_idx_next = '0;
                end
                else if (req.status)
                begin
                    state_next = bsf_pkg::EMIT_STATUS;
                    cnt_next   = '0;
                end
            end
            bsf_pkg::EMIT_FRAME:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = bsf_pkg::KIND_FRAME;
                    out_last_next  = (cnt_reg == CNT_W'(TOTAL - 1));
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg < CNT_W'(bsf_pkg::HDR_BYTES))
                    begin
                        unique case (cnt_reg[2:0])
                            3'd0:    out_byte_next = hdr.seq[7:0];
                            3'd1:    out_byte_next = hdr.seq[15:8];
                            3'd2:    out_byte_next = hdr.frame_time[7:0];
                            3'd3:    out_byte_next = hdr.frame_time[15:8];
                            3'd4:    out_byte_next = hdr.frame_time[23:16];
                            default: out_byte_next = hdr.frame_time[31:24];
                        endcase
                    end
                    else if (!cnt_reg[0])
                    begin
                        out_byte_next = sample_ofs[7:0];
                        hi_next       = sample_ofs[15:8];
                        if (rd_idx_reg == IDX_W'(FRAME_SAMPLES - 1))
                        begin
                            rd_idx_next = '0;
                        end
                        else
                        begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_byte_next = hi_reg;
                    end
                    if (cnt_reg == CNT_W'(TOTAL - 1))
                    begin
                        state_next = bsf_pkg::EMIT_IDLE;
                    end
                end
            end
            bsf_pkg::EMIT_STATUS:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = bsf_pkg::KIND_STATUS;
                    out_last_next  = (cnt_reg[1:0] == 2'd3);
                    cnt_next       = cnt_reg + 1'b1;
                    unique case (cnt_reg[1:0])
                        2'd0:    out_byte_next = hdr.flags;
                        2'd1:    out_byte_next = bsf_pkg::STATUS_MARK;
                        2'd2:    out_byte_next = hdr.seq[7:0];
                        default: out_byte_next = hdr.seq[15:8];
                    endcase
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_next = bsf_pkg::EMIT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bsf_pkg::EMIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsf_pkg::EMIT_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg       <= hi_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.packet_kind = out_kind_reg;
    assign result.last        = out_last_reg;

endmodule

>>> sv/biosignal_sample_framer.sv
// ecg sample framer top level: command handling, deadline and frame bookkeeping
// Sample ticks that complete no frame and control writes cause no output and leave
// the block ready for the next item. A tick that completes a frame starts a packet of
// 6 + 2*FRAME_SAMPLES bytes and a status request a packet of 4 bytes; packets leave
// one word per cycle while the receiver takes them, from a single output register:
// the packer's state register is set when the item is taken, then the first word
// enters the output register. Samples are read from the frame store one per two words
// through its single registered read port, and the next item can be taken the cycle
// after the last word of the packet enters the output register, later while the
// receiver holds off. The store needs no clearing after reset.
module biosignal_sample_framer #(
    parameter int FRAME_SAMPLES = bsf_pkg::FRAME_SAMPLES_DEF,
    parameter int ADC_BITS      = bsf_pkg::ADC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bsf_item_if.sink      item,
    bsf_result_if.source  result
);

    localparam int SAMPLE_W = (ADC_BITS < bsf_pkg::ADC_IN_W) ? ADC_BITS : bsf_pkg::ADC_IN_W;
    localparam int IDX_W    = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

    logic             streaming_reg, streaming_next;
    logic             armed_reg, armed_next;
    logic [31:0]      deadline_reg, deadline_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [31:0]      frame_time_reg, frame_time_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      last_sent_reg, last_sent_next;
    logic             plus_reg, plus_next;
    logic             minus_reg, minus_next;

    logic             accept;
    logic             busy;
    logic [31:0]      diff;
    logic             expired;
    logic             stream_eff;
    logic             wr_en;
    bsf_pkg::func_t   func_e;
    bsf_pkg::pkt_req_t req;
    bsf_pkg::hdr_t    hdr;

    assign item.ready = !busy;
    assign accept     = item.valid && !busy;
    assign func_e     = bsf_pkg::func_t'(item.func);
    assign diff       = item.now_ms - deadline_reg;
    assign expired    = streaming_reg && armed_reg && !diff[31];
    assign stream_eff = streaming_reg && !expired;

    always_comb
    begin
        streaming_next  = streaming_reg;
        armed_next      = armed_reg;
        deadline_next   = deadline_reg;
        widx_next       = widx_reg;
        frame_time_next = frame_time_reg;
        seq_next        = seq_reg;
        last_sent_next  = last_sent_reg;
        plus_next       = plus_reg;
        minus_next      = minus_reg;
        wr_en           = 1'b0;
        req             = '0;

        if (accept)
        begin
            if (expired)
            begin
                streaming_next = 1'b0;
                armed_next     = 1'b0;
                deadline_next  = '0;
            end
            unique case (func_e)
                bsf_pkg::FUNC_TICK:
                begin
                    if (stream_eff)
                    begin
                        plus_next  = item.lead_plus_off;
                        minus_next = item.lead_minus_off;
                        wr_en      = 1'b1;
                        if (widx_reg == '0)
                        begin
                            frame_time_next = item.now_ms;
                        end
                        if (widx_reg == IDX_W'(FRAME_SAMPLES - 1))
                        begin
                            widx_next      = '0;
                            seq_next       = seq_reg + 1'b1;
                            last_sent_next = seq_reg;
                            req.frame      = 1'b1;
                        end
                        else
                        begin
                            widx_next = widx_reg + 1'b1;
                        end
                    end
                end
                bsf_pkg::FUNC_CTRL:
                begin
                    priority if (item.opcode == bsf_pkg::OP_START)
                    begin
                        streaming_next = 1'b1;
                        armed_next     = 1'b0;
                        deadline_next  = '0;
                    end
                    else if (item.opcode == bsf_pkg::OP_STOP)
                    begin
                        streaming_next = 1'b0;
                        armed_next     = 1'b0;
                        deadline_next  = '0;
                    end
                    else if (item.opcode == bsf_pkg::OP_TIMED)
                    begin
                        streaming_next = 1'b1;
                        armed_next     = 1'b1;
                        deadline_next  = item.now_ms + 32'(item.arg) * bsf_pkg::MS_PER_S;
                    end
                    else
                    begin
                    end
                end
                bsf_pkg::FUNC_STATUS:
                begin
                    req.status = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        hdr            = '0;
        hdr.seq        = last_sent_reg;
        hdr.frame_time = frame_time_reg;
        hdr.flags[bsf_pkg::FLAG_PLUS_BIT]   = plus_reg;
        hdr.flags[bsf_pkg::FLAG_MINUS_BIT]  = minus_reg;
        hdr.flags[bsf_pkg::FLAG_STREAM_BIT] = streaming_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streaming_reg  <= 1'b0;
            armed_reg      <= 1'b0;
            deadline_reg   <= '0;
            widx_reg       <= '0;
            frame_time_reg <= '0;
            seq_reg        <= '0;
            last_sent_reg  <= '0;
            plus_reg       <= 1'b0;
            minus_reg      <= 1'b0;
        end
        else
        begin
            streaming_reg  <= streaming_next;
            armed_reg      <= armed_next;
            deadline_reg   <= deadline_next;
            widx_reg       <= widx_next;
            frame_time_reg <= frame_time_next;
            seq_reg        <= seq_next;
            last_sent_reg  <= last_sent_next;
            plus_reg       <= plus_next;
            minus_reg      <= minus_next;
        end
    end

    bsf_packer #(
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .ADC_BITS      (ADC_BITS)
    ) u_packer (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (widx_reg),
        .wr_data (item.adc_value[SAMPLE_W-1:0]),
        .req     (req),
        .hdr     (hdr),
        .busy    (busy),
        .result  (result)
    );

endmodule
